[rtl/tcpl_pkg.sv]
`timescale 1ns / 1ps

package tcpl_pkg;

    // Beat field widths
    localparam int ACTION_W = 2;
    localparam int PORT_W   = 16;
    localparam int IP_W     = 32;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = PORT_W + IP_W;

    // Operation codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

    // Request held steady while its token walks the chain
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] hnd;
    } t_req;

    // Token handed from cell to cell.
    // Scan pass: hit/hit_hnd collect the match, free marks a free entry seen.
    // Claim pass: free means the write is still looking for a home.
    typedef struct packed {
        logic                vld;
        logic                claim;
        logic                hit;
        logic [HANDLE_W-1:0] hit_hnd;
        logic                free;
    } t_tok;

endpackage

[rtl/tcpl_in_if.sv]
`timescale 1ns / 1ps

interface tcpl_in_if;
    logic                          valid;
    logic                          ready;
    logic [tcpl_pkg::ACTION_W-1:0] action;
    logic [tcpl_pkg::PORT_W-1:0]   listen_port;
    logic [tcpl_pkg::IP_W-1:0]     local_ip;
    logic [tcpl_pkg::HANDLE_W-1:0] handle_in;

    modport source (output valid, action, listen_port, local_ip, handle_in, input ready);
    modport sink   (input valid, action, listen_port, local_ip, handle_in, output ready);
endinterface

[rtl/tcpl_out_if.sv]
`timescale 1ns / 1ps

interface tcpl_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcpl_pkg::STATUS_W-1:0] status;
    logic [tcpl_pkg::HANDLE_W-1:0] handle_out;

    modport source (output valid, status, handle_out, input ready);
    modport sink   (input valid, status, handle_out, output ready);
endinterface

[rtl/tcpl_cell.sv]
`timescale 1ns / 1ps

module tcpl_cell #(
    parameter int HB = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcpl_pkg::t_req   i_req,
    input  tcpl_pkg::t_tok   i_tok,
    output tcpl_pkg::t_tok   o_tok
);

    logic                       r_valid, n_valid;
    logic [tcpl_pkg::KEY_W-1:0] r_key;
    logic [HB-1:0]              r_hnd;
    tcpl_pkg::t_tok             r_tok, n_tok;
    logic                       w_match;
    logic                       w_wr;

    assign w_match = r_valid && (r_key == i_req.key);

    // Entry update and token hand-off
    always_comb begin
        n_valid = r_valid;
        n_tok   = i_tok;
        w_wr    = 1'b0;
        if (i_tok.vld) begin
            if (!i_tok.claim) begin
                n_tok.hit  = i_tok.hit | w_match;
                n_tok.free = i_tok.free | !r_valid;
                if (w_match) begin
                    n_tok.hit_hnd = tcpl_pkg::HANDLE_W'(r_hnd);
                end
                // keys are unique, so removing on the way is safe
                if (i_req.action == tcpl_pkg::ACT_REMOVE && w_match &&
                    r_hnd == i_req.hnd[HB-1:0]) begin
                    n_valid = 1'b0;
                end
            end else if (i_tok.free && !r_valid) begin
                // lowest free entry takes the insert
                n_valid    = 1'b1;
                w_wr       = 1'b1;
                n_tok.free = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    // Key and handle storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_key <= i_req.key;
            r_hnd <= i_req.hnd[HB-1:0];
        end
    end

    assign o_tok = r_tok;

endmodule

[rtl/tcp_listener_lookup_table.sv]
`timescale 1ns / 1ps

// Listener lookup table.
// i_in carries one request beat: action (insert, lookup, remove), the key
// (listen_port, local_ip) and handle_in. o_out returns one result beat per
// request: status and handle_out (nonzero only on a lookup hit).
// Entries sit in a chain of ENTRIES cells. A request token walks the chain
// one cell per cycle; each cell compares its key, frees itself on a matching
// remove and reports a hit or a free entry. An insert that finds no duplicate
// and a free entry sends a second claim token down the chain, and the first
// free cell stores the key.
// A result beat follows once the scan token leaves the last cell, and for an
// insert that stores, once the claim token has also walked the chain. One
// request is in the chain at a time; the next is taken after the result loads.
// i_in.ready is high only while the chain is empty. A result that cannot leave
// because o_out.ready is low waits in the result register and the next request
// is still taken; its result then waits until the register drains.
// Reset clears all valid marks at once; the table is empty afterwards.
module tcp_listener_lookup_table #(
    parameter int ENTRIES     = 16,
    parameter int HANDLE_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcpl_in_if.sink    i_in,
    tcpl_out_if.source o_out
);

    localparam int HB = (HANDLE_BITS < tcpl_pkg::HANDLE_W) ? HANDLE_BITS
                                                           : tcpl_pkg::HANDLE_W;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SCAN    = 4'b0010,
        S_CLAIM   = 4'b0100,
        S_DELIVER = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    tcpl_pkg::t_req                  r_req;
    tcpl_pkg::t_tok                  r_head, n_head;
    logic [tcpl_pkg::STATUS_W-1:0]   r_res_st, n_res_st;
    logic [tcpl_pkg::HANDLE_W-1:0]   r_res_hnd, n_res_hnd;
    logic                            r_out_vld, n_out_vld;
    logic [tcpl_pkg::STATUS_W-1:0]   r_out_st;
    logic [tcpl_pkg::HANDLE_W-1:0]   r_out_hnd;
    tcpl_pkg::t_tok                  w_tok [ENTRIES+1];
    tcpl_pkg::t_tok                  w_tail;
    logic                            w_in_beat;
    logic                            w_load_out;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in.valid && i_in.ready;
    assign w_tail     = w_tok[ENTRIES];
    assign w_load_out = (r_state == S_DELIVER) && (!r_out_vld || o_out.ready);

    // Cell chain
    assign w_tok[0] = r_head;
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        tcpl_cell #(.HB(HB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (r_req),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_head    = '0;
        n_res_st  = r_res_st;
        n_res_hnd = r_res_hnd;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_head.vld = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tail.vld) begin
                    n_res_hnd = '0;
                    n_state   = S_DELIVER;
                    case (r_req.action)
                        tcpl_pkg::ACT_INSERT: begin
                            if (w_tail.hit) begin
                                n_res_st = tcpl_pkg::ST_DUP;
                            end else if (w_tail.free) begin
                                n_res_st     = tcpl_pkg::ST_DONE;
                                n_head.vld   = 1'b1;
                                n_head.claim = 1'b1;
                                n_head.free  = 1'b1;
                                n_state      = S_CLAIM;
                            end else begin
                                n_res_st = tcpl_pkg::ST_FULL;
                            end
                        end
                        tcpl_pkg::ACT_LOOKUP: begin
                            if (w_tail.hit) begin
                                n_res_st  = tcpl_pkg::ST_DONE;
                                n_res_hnd = w_tail.hit_hnd;
                            end else begin
                                n_res_st = tcpl_pkg::ST_MISS;
                            end
                        end
                        tcpl_pkg::ACT_REMOVE: begin
                            if (w_tail.hit && w_tail.hit_hnd == r_req.hnd) begin
                                n_res_st = tcpl_pkg::ST_DONE;
                            end else begin
                                n_res_st = tcpl_pkg::ST_MISS;
                            end
                        end
                        default: begin
                            n_res_st = tcpl_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            S_CLAIM: begin
                if (w_tail.vld) begin
                    n_state = S_DELIVER;
                end
            end
            S_DELIVER: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        n_out_vld = r_out_vld;
        if (w_load_out) begin
            n_out_vld = 1'b1;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_res_st  <= n_res_st;
        r_res_hnd <= n_res_hnd;
        if (w_in_beat) begin
            r_req.action <= i_in.action;
            r_req.key    <= {i_in.listen_port, i_in.local_ip};
            r_req.hnd    <= tcpl_pkg::HANDLE_W'(i_in.handle_in[HB-1:0]);
        end
        if (w_load_out) begin
            r_out_st  <= r_res_st;
            r_out_hnd <= r_res_hnd;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.status     = r_out_st;
    assign o_out.handle_out = r_out_hnd;

endmodule

[rtl/tcpl_checker.sv]
`timescale 1ns / 1ps

module tcpl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tcpl_pkg::STATUS_W-1:0] i_out_status,
    input logic [tcpl_pkg::HANDLE_W-1:0] i_out_handle
);

    // A result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // A nonzero handle only comes with a hit
    a_hnd_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_handle != '0 |-> i_out_status == tcpl_pkg::ST_DONE)
        else $error("handle shown without a hit");

    // The block is busy right after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while one is in the chain");

    // Reset leaves no result pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind tcp_listener_lookup_table tcpl_checker u_tcpl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_handle (o_out.handle_out)
);
